[src/timestamp_barrier_sync_assert.svh]
// Assertion macros shared by the barrier synchronization RTL.
`ifndef TIMESTAMP_BARRIER_SYNC_ASSERT_SVH
`define TIMESTAMP_BARRIER_SYNC_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TBS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("barrier sync assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define TBS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("barrier sync assertion failed");

`endif

[src/tbs_pkg.sv]
// Shared types and constants of the barrier synchronization unit.
package tbs_pkg;

    localparam int DEF_MAX_THREADS = 16;

    localparam int CMD_W = 3;
    localparam int ID_W  = 5;
    localparam int TS_W  = 64;
    localparam int ARG_W = 64;
    localparam int STS_W = 2;
    localparam int TC_W  = 5;

    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-1:0] REG_THREAD_COUNT = 2'd0;

    localparam logic [CMD_W-1:0] CMD_REGISTER      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SYNC_START    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MARK_USED     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET_ARG       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SYNC_COMPLETE = 3'd4;

    localparam logic [STS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STS_W-1:0] STATUS_OUT_OF_SYNC = 2'd1;
    localparam logic [STS_W-1:0] STATUS_NOT_USED    = 2'd2;
    localparam logic [STS_W-1:0] STATUS_BAD_ID      = 2'd3;

    typedef struct packed {
        logic             used;
        logic [ARG_W-1:0] arg;
        logic [TS_W-1:0]  stamp;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } state_t;

endpackage

[src/tbs_if.sv]
// Request and response channel interfaces of the barrier synchronization unit.
interface tbs_req_if;
    logic                        valid;
    logic                        ready;
    logic [tbs_pkg::CMD_W-1:0]   cmd;
    logic [tbs_pkg::ID_W-1:0]    member_id;
    logic [tbs_pkg::TS_W-1:0]    epoch_stamp;
    logic [tbs_pkg::ARG_W-1:0]   arg_value;

    modport source (output valid, output cmd, output member_id, output epoch_stamp,
                    output arg_value, input ready);
    modport sink   (input valid, input cmd, input member_id, input epoch_stamp,
                    input arg_value, output ready);
endinterface

interface tbs_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tbs_pkg::STS_W-1:0]   status;
    logic [tbs_pkg::ID_W-1:0]    assigned_id;
    logic [tbs_pkg::ARG_W-1:0]   arg_out;

    modport source (output valid, output status, output assigned_id, output arg_out,
                    input ready);
    modport sink   (input valid, input status, input assigned_id, input arg_out,
                    output ready);
endinterface

[src/tbs_table.sv]
// Participant table: one synchronous memory with per-entry valid bits.
module tbs_table #(
    parameter int MAX_THREADS = tbs_pkg::DEF_MAX_THREADS,
    localparam int IDX_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output tbs_pkg::entry_t      rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  tbs_pkg::entry_t      wr_data
);

    tbs_pkg::entry_t        mem [MAX_THREADS];
    tbs_pkg::entry_t        q_reg;
    logic [MAX_THREADS-1:0] valid_reg;
    logic                   hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    // An entry never written since reset reads as all zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? q_reg : '0;

endmodule

[src/timestamp_barrier_sync.sv]
// Top level of the time-stamped barrier synchronization unit.
// This unit keeps a table of up to MAX_THREADS participants, each with a 64-bit time
// stamp, a 64-bit argument word and a used flag, all zero after reset, in one
// synchronous memory. Commands arrive as beats on the req channel and each gives
// exactly one response beat on rsp. The unit works on one command at a time: a
// register, sync_start, mark_used or get_arg command reads its entry on the accepting
// edge; the read state then does the update and the response load once the response
// slot is free, and only then can a new command be taken. sync_complete first updates
// the caller's used flag and then scans the active participants through the single
// memory read port, one per cycle, before its response is loaded; the read port is
// what sets how long the command takes. A response waiting on rsp does not block the
// next request from being accepted; it only holds the following command at its final
// step. The participant count is written over the APB port at address 0; the user
// must write it only while the unit is idle, which the block itself does not enforce.
// pready is always high and prdata returns the count.
`include "timestamp_barrier_sync_assert.svh"

module timestamp_barrier_sync #(
    parameter int MAX_THREADS = tbs_pkg::DEF_MAX_THREADS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tbs_req_if.sink                       req,
    tbs_rsp_if.source                     rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbs_pkg::PADDR_W-1:0]   paddr,
    input  logic [tbs_pkg::PDATA_W-1:0]   pwdata,
    output logic [tbs_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int IDX_W  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CNT_RAW = $clog2(MAX_THREADS + 1);
    localparam int CNT_W  = (CNT_RAW > tbs_pkg::TC_W) ? CNT_RAW : tbs_pkg::TC_W;
    localparam int NID_W  = CNT_W + 1;

    // Control state.
    tbs_pkg::state_t               state_reg, state_next;
    logic [tbs_pkg::TC_W-1:0]      thread_count_reg;
    logic [NID_W-1:0]              next_id_reg, next_id_next;
    logic [CNT_W-1:0]              scan_idx_reg, scan_idx_next;
    logic                          pend_reg, pend_next;
    logic                          mism_reg, mism_next;
    logic                          unused_reg, unused_next;
    logic                          out_valid_reg, out_valid_next;

    // Latched command.
    logic [tbs_pkg::CMD_W-1:0]     cmd_reg;
    logic [IDX_W-1:0]              slot_reg;
    logic [tbs_pkg::TS_W-1:0]      ts_reg;
    logic [tbs_pkg::ARG_W-1:0]     av_reg;
    logic                          bad_reg;

    // Response register.
    logic [tbs_pkg::STS_W-1:0]     out_status_reg, out_status_next;
    logic [tbs_pkg::ID_W-1:0]      out_id_reg, out_id_next;
    logic [tbs_pkg::ARG_W-1:0]     out_arg_reg, out_arg_next;
    logic                          out_load;

    // Memory ports.
    logic                          rd_en;
    logic [IDX_W-1:0]              rd_addr;
    tbs_pkg::entry_t               rd_data;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    tbs_pkg::entry_t               wr_data;

    logic [CNT_W-1:0]              active_count;
    logic [CNT_W-1:0]              tc_ext;
    logic [CNT_W-1:0]              id_ext;
    logic                          id_ok;
    logic                          cmd_needs_id;
    logic                          accept;
    logic                          out_free;
    logic                          stamp_match;
    logic                          scan_done;
    logic                          cfg_wr;

    // The active count is the programmed count capped at the table depth.
    assign tc_ext       = CNT_W'(thread_count_reg);
    assign active_count = (tc_ext < CNT_W'(MAX_THREADS)) ? tc_ext : CNT_W'(MAX_THREADS);

    // A thread id is checked at accept time, against the count in force then.
    assign id_ext       = CNT_W'(req.member_id);
    assign id_ok        = (id_ext != '0) && (id_ext <= active_count);
    assign cmd_needs_id = (req.cmd == tbs_pkg::CMD_SYNC_START)
                       || (req.cmd == tbs_pkg::CMD_MARK_USED)
                       || (req.cmd == tbs_pkg::CMD_GET_ARG)
                       || (req.cmd == tbs_pkg::CMD_SYNC_COMPLETE);

    assign req.ready = (state_reg == tbs_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;

    // The response slot can take a new beat when empty or when it drains this cycle.
    assign out_free    = !out_valid_reg || rsp.ready;
    assign stamp_match = (rd_data.stamp == ts_reg);
    assign scan_done   = (scan_idx_reg == active_count) && !pend_reg;

    tbs_table #(
        .MAX_THREADS (MAX_THREADS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Next state. A sync_complete with a valid id moves on to the scan; every other command
    // finishes in the read state once the response slot is free.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tbs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = tbs_pkg::ST_READ;
                end
            end
            tbs_pkg::ST_READ:
            begin
                if (!bad_reg && (cmd_reg == tbs_pkg::CMD_SYNC_COMPLETE))
                begin
                    state_next = tbs_pkg::ST_SCAN;
                end
                else if (out_free)
                begin
                    state_next = tbs_pkg::ST_IDLE;
                end
            end
            tbs_pkg::ST_SCAN:
            begin
                if (scan_done && out_free)
                begin
                    state_next = tbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tbs_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory accesses, scan bookkeeping and the response contents.
    always_comb
    begin
        rd_en           = 1'b0;
        rd_addr         = IDX_W'(id_ext - CNT_W'(1));
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_data         = rd_data;
        out_load        = 1'b0;
        out_status_next = tbs_pkg::STATUS_OK;
        out_id_next     = '0;
        out_arg_next    = '0;
        next_id_next    = next_id_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = 1'b0;
        mism_next       = mism_reg;
        unused_next     = unused_reg;

        unique case (state_reg)
            tbs_pkg::ST_IDLE:
            begin
                // Fetch the caller's entry; harmless for commands that ignore it.
                rd_en = accept;
            end
            tbs_pkg::ST_READ:
            begin
                out_load = out_free;
                if (bad_reg)
                begin
                    out_status_next = tbs_pkg::STATUS_BAD_ID;
                end
                else
                begin
                    case (cmd_reg)
                        tbs_pkg::CMD_REGISTER:
                        begin
                            if (next_id_reg <= NID_W'(active_count))
                            begin
                                out_id_next = next_id_reg[tbs_pkg::ID_W-1:0];
                                if (out_free)
                                begin
                                    next_id_next = next_id_reg + NID_W'(1);
                                end
                            end
                        end
                        tbs_pkg::CMD_SYNC_START:
                        begin
                            wr_en         = out_free;
                            wr_data.used  = 1'b0;
                            wr_data.arg   = av_reg;
                            wr_data.stamp = ts_reg;
                        end
                        tbs_pkg::CMD_MARK_USED:
                        begin
                            if (stamp_match)
                            begin
                                wr_en        = out_free;
                                wr_data.used = 1'b1;
                            end
                            else
                            begin
                                out_status_next = tbs_pkg::STATUS_OUT_OF_SYNC;
                            end
                        end
                        tbs_pkg::CMD_GET_ARG:
                        begin
                            if (stamp_match)
                            begin
                                out_arg_next = rd_data.arg;
                            end
                            else
                            begin
                                out_status_next = tbs_pkg::STATUS_OUT_OF_SYNC;
                            end
                        end
                        tbs_pkg::CMD_SYNC_COMPLETE:
                        begin
                            // Mark the caller now if its stamp matches; the scan starts in the next cycle, so
                            // it reads the updated entry.
                            out_load      = 1'b0;
                            wr_en         = stamp_match;
                            wr_data.used  = 1'b1;
                            scan_idx_next = '0;
                            mism_next     = 1'b0;
                            unused_next   = 1'b0;
                        end
                        default:
                        begin
                            out_status_next = tbs_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            tbs_pkg::ST_SCAN:
            begin
                // Issue one read per cycle and check the beat read in the previous cycle.
                rd_addr = scan_idx_reg[IDX_W-1:0];
                if (scan_idx_reg < active_count)
                begin
                    rd_en         = 1'b1;
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                pend_next = rd_en;
                if (pend_reg)
                begin
                    mism_next   = mism_reg || (rd_data.stamp != ts_reg);
                    unused_next = unused_reg || !rd_data.used;
                end
                out_load = scan_done && out_free;
                if (mism_reg)
                begin
                    out_status_next = tbs_pkg::STATUS_OUT_OF_SYNC;
                end
                else if (unused_reg)
                begin
                    out_status_next = tbs_pkg::STATUS_NOT_USED;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tbs_pkg::ST_IDLE;
            thread_count_reg <= '0;
            next_id_reg      <= NID_W'(1);
            scan_idx_reg     <= '0;
            pend_reg         <= 1'b0;
            mism_reg         <= 1'b0;
            unused_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            bad_reg          <= 1'b0;
            cmd_reg          <= tbs_pkg::CMD_REGISTER;
        end
        else
        begin
            state_reg     <= state_next;
            next_id_reg   <= next_id_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            mism_reg      <= mism_next;
            unused_reg    <= unused_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr && (paddr == tbs_pkg::REG_THREAD_COUNT))
            begin
                thread_count_reg <= pwdata[tbs_pkg::TC_W-1:0];
            end
            if (accept)
            begin
                cmd_reg <= req.cmd;
                bad_reg <= cmd_needs_id && !id_ok;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg <= IDX_W'(id_ext - CNT_W'(1));
            ts_reg   <= req.epoch_stamp;
            av_reg   <= req.arg_value;
        end
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_id_reg     <= out_id_next;
            out_arg_reg    <= out_arg_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.assigned_id = out_id_reg;
    assign rsp.arg_out     = out_arg_reg;

    // APB register port.
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr == tbs_pkg::REG_THREAD_COUNT)
                  ? {{(tbs_pkg::PDATA_W - tbs_pkg::TC_W){1'b0}}, thread_count_reg}
                  : '0;

    // A write never lands on the entry being read in the same cycle.
    `TBS_ASSERT_IMP(a_no_rw_collision, wr_en && rd_en, wr_addr != rd_addr)
    // Every accepted request goes through the read of its entry.
    `TBS_ASSERT_NXT(a_accept_reads, req.valid && req.ready, state_reg == tbs_pkg::ST_READ)
    // The scan never runs past the active participants.
    `TBS_ASSERT_IMP(a_scan_bound, state_reg == tbs_pkg::ST_SCAN, scan_idx_reg <= active_count)
    // A handed-out id is always within the active range.
    `TBS_ASSERT_IMP(a_id_in_range, out_load && (out_id_next != '0), CNT_W'(out_id_next) <= active_count)

endmodule

[test/timestamp_barrier_sync_test.sv]
// Self-checking testbench of the time-stamped barrier synchronization unit.

// One response beat as the barrier unit should produce it.
typedef struct {
    logic [tbs_pkg::STS_W-1:0] status;
    logic [tbs_pkg::ID_W-1:0]  assigned_id;
    logic [tbs_pkg::ARG_W-1:0] arg_out;
} barrier_rsp_t;

// Keeps its own copy of the participant table, works out the response of every
// accepted command and compares the response beats against it in order.
class barrier_scoreboard;
    logic [tbs_pkg::TS_W-1:0]  stamps [tbs_pkg::DEF_MAX_THREADS];
    logic [tbs_pkg::ARG_W-1:0] args   [tbs_pkg::DEF_MAX_THREADS];
    bit                        used   [tbs_pkg::DEF_MAX_THREADS];
    int unsigned               next_id;
    int unsigned               thread_count;
    barrier_rsp_t              expected_rsps [$];
    int                        mismatches;
    int                        checked;
    int                        status_seen [4];

    function new();
        foreach (stamps[k])
        begin
            stamps[k] = '0;
            args[k]   = '0;
            used[k]   = 1'b0;
        end
        foreach (status_seen[k])
            status_seen[k] = 0;
        next_id      = 1;
        thread_count = 0;
        mismatches   = 0;
        checked      = 0;
    endfunction

    function int unsigned live_count();
        return (thread_count < tbs_pkg::DEF_MAX_THREADS) ? thread_count
                                                          : tbs_pkg::DEF_MAX_THREADS;
    endfunction

    function void set_count(input logic [tbs_pkg::TC_W-1:0] value);
        thread_count = 32'(value);
    endfunction

    function void note_request(input logic [tbs_pkg::CMD_W-1:0] cmd,
                               input logic [tbs_pkg::ID_W-1:0]  id,
                               input logic [tbs_pkg::TS_W-1:0]  ts,
                               input logic [tbs_pkg::ARG_W-1:0] av);
        barrier_rsp_t want;
        int           slot;
        bit           in_sync;
        bit           all_used;
        want = '{default: 0};
        slot = int'(id) - 1;
        if (cmd >= tbs_pkg::CMD_SYNC_START && cmd <= tbs_pkg::CMD_SYNC_COMPLETE
            && !(id >= 1 && id <= live_count()))
        begin
            // A bad id on a table command changes nothing and skips the scan.
            want.status = tbs_pkg::STATUS_BAD_ID;
        end
        else
        begin
            case (cmd)
                tbs_pkg::CMD_REGISTER:
                begin
                    if (next_id <= live_count())
                    begin
                        want.assigned_id = next_id[tbs_pkg::ID_W-1:0];
                        next_id++;
                    end
                end
                tbs_pkg::CMD_SYNC_START:
                begin
                    used[slot]   = 1'b0;
                    args[slot]   = av;
                    stamps[slot] = ts;
                end
                tbs_pkg::CMD_MARK_USED:
                begin
                    if (stamps[slot] == ts)
                        used[slot] = 1'b1;
                    else
                        want.status = tbs_pkg::STATUS_OUT_OF_SYNC;
                end
                tbs_pkg::CMD_GET_ARG:
                begin
                    if (stamps[slot] == ts)
                        want.arg_out = args[slot];
                    else
                        want.status = tbs_pkg::STATUS_OUT_OF_SYNC;
                end
                tbs_pkg::CMD_SYNC_COMPLETE:
                begin
                    if (stamps[slot] == ts)
                        used[slot] = 1'b1;
                    in_sync  = 1'b1;
                    all_used = 1'b1;
                    for (int k = 0; k < live_count(); k++)
                    begin
                        if (stamps[k] != ts)
                            in_sync = 1'b0;
                        if (!used[k])
                            all_used = 1'b0;
                    end
                    if (!in_sync)
                        want.status = tbs_pkg::STATUS_OUT_OF_SYNC;
                    else if (!all_used)
                        want.status = tbs_pkg::STATUS_NOT_USED;
                    else
                        want.status = tbs_pkg::STATUS_OK;
                end
                default:
                    ;
            endcase
        end
        expected_rsps.push_back(want);
    endfunction

    task report_mismatch(input string msg);
        $display("MISMATCH (response beat %0d): %s", checked, msg);
        mismatches++;
    endtask

    task check_response(input logic [tbs_pkg::STS_W-1:0] status,
                        input logic [tbs_pkg::ID_W-1:0]  assigned_id,
                        input logic [tbs_pkg::ARG_W-1:0] arg_out);
        barrier_rsp_t want;
        if (expected_rsps.size() == 0)
        begin
            report_mismatch("response beat with no command outstanding");
            return;
        end
        want = expected_rsps.pop_front();
        checked++;
        status_seen[want.status]++;
        if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (assigned_id !== want.assigned_id)
            report_mismatch($sformatf("assigned_id %0d, expected %0d",
                                      assigned_id, want.assigned_id));
        if (arg_out !== want.arg_out)
            report_mismatch($sformatf("arg_out %h, expected %h", arg_out, want.arg_out));
    endtask
endclass

module timestamp_barrier_sync_test;

    localparam int RESET_CYCLES     = 9;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int LONG_HOLD_CYCLES = 300;
    // The longest command is a full scan of sixteen participants plus its read and
    // response steps, so this covers any work still in flight.
    localparam int DRAIN_CYCLES     = 2 * tbs_pkg::DEF_MAX_THREADS + 8;
    localparam int TARGET_ITEMS     = 450;
    localparam int PHASE_BUDGET     = 60;
    localparam int EMPTY_BUDGET     = 15;
    localparam int MAX_GAP          = 15;
    localparam logic [tbs_pkg::ID_W-1:0] MAX_WIRE_ID = 5'd31;

    // Command codes outside the defined set; the unit must answer them with zeros.
    localparam logic [tbs_pkg::CMD_W-1:0] CMD_RESERVED_LO = 3'd5;
    localparam logic [tbs_pkg::CMD_W-1:0] CMD_RESERVED_HI = 3'd7;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [tbs_pkg::PADDR_W-1:0] paddr;
    logic [tbs_pkg::PDATA_W-1:0] pwdata;
    logic [tbs_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    tbs_req_if req ();
    tbs_rsp_if rsp ();

    barrier_scoreboard sb;

    // When set, both sides stop idling so that commands run back to back.
    bit          brisk;
    // Raised by the stimulus once; the response side then holds off for a long
    // stretch while commands keep coming, so the unit fills up and stalls.
    bit          long_hold_request;
    int unsigned long_holds;
    int unsigned items_sent;
    int unsigned settings_used;
    int unsigned cycles;
    logic [tbs_pkg::TS_W-1:0] last_epoch;

    timestamp_barrier_sync dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog: a hung handshake or a lost response ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d responses outstanding.",
                     cycles, sb.expected_rsps.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Monitor. Everything is sampled at the rising edge, before any of this
    // edge's nonblocking updates land, so a beat is seen exactly when it is
    // accepted. Responses are checked before the new command is noted; a
    // response can never belong to a command accepted on the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                sb.check_response(rsp.status, rsp.assigned_id, rsp.arg_out);
            if (req.valid && req.ready)
                sb.note_request(req.cmd, req.member_id, req.epoch_stamp, req.arg_value);
            if (psel && penable && pwrite && pready && paddr == tbs_pkg::REG_THREAD_COUNT)
                sb.set_count(pwdata[tbs_pkg::TC_W-1:0]);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Epoch stamps lean on the all-zero and all-one extremes now and then; an
    // all-zero stamp also matches entries that were never started.
    function automatic logic [tbs_pkg::TS_W-1:0] pick_stamp();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return rand64();
        endcase
    endfunction

    // Offers one command beat after a random gap and returns at the edge that
    // accepts it. valid stays high across back-to-back beats.
    task automatic send_beat(input logic [tbs_pkg::CMD_W-1:0] cmd,
                             input logic [tbs_pkg::ID_W-1:0]  id,
                             input logic [tbs_pkg::TS_W-1:0]  ts,
                             input logic [tbs_pkg::ARG_W-1:0] av);
        int gap;
        gap = brisk ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.cmd         <= cmd;
        req.member_id   <= id;
        req.epoch_stamp <= ts;
        req.arg_value   <= av;
        do @(posedge clk); while (!req.ready);
        items_sent++;
    endtask

    // APB write of the participant count, with a setup and an access phase. The bits above the count
    // field carry random junk, which the unit must ignore.
    task automatic write_thread_count(input int unsigned count);
        logic [tbs_pkg::PDATA_W-1:0] word;
        word = $urandom;
        word[tbs_pkg::TC_W-1:0] = count[tbs_pkg::TC_W-1:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tbs_pkg::REG_THREAD_COUNT;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // Stops offering commands and waits until every response has come back and
    // the unit has had time to finish whatever it was still doing.
    task automatic settle();
        req.valid <= 1'b0;
        while (sb.expected_rsps.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // A well-formed barrier epoch: every participant starts with a shared stamp,
    // some read their argument or mark it used, then all complete in a random
    // order. A few beats carry a stray stamp so mismatches show up mid-epoch.
    task automatic barrier_round(input int unsigned n);
        logic [tbs_pkg::TS_W-1:0] epoch;
        logic [tbs_pkg::ID_W-1:0] order [$];
        epoch      = pick_stamp();
        last_epoch = epoch;
        for (int j = 1; j <= n; j++)
            order.push_back(j[tbs_pkg::ID_W-1:0]);
        order.shuffle();
        foreach (order[i])
            send_beat(tbs_pkg::CMD_SYNC_START, order[i],
                      ($urandom_range(0, 9) == 0) ? rand64() : epoch, rand64());
        foreach (order[i])
        begin
            case ($urandom_range(0, 3))
                0:       send_beat(tbs_pkg::CMD_MARK_USED, order[i],
                                   ($urandom_range(0, 7) == 0) ? rand64() : epoch, rand64());
                1:       send_beat(tbs_pkg::CMD_GET_ARG, order[i],
                                   ($urandom_range(0, 7) == 0) ? rand64() : epoch, rand64());
                default: ;
            endcase
        end
        order.shuffle();
        foreach (order[i])
            send_beat(tbs_pkg::CMD_SYNC_COMPLETE, order[i],
                      ($urandom_range(0, 11) == 0) ? rand64() : epoch, rand64());
    endtask

    // Any command, reserved codes included, with ids mostly near the valid
    // range and sometimes anywhere the five-bit field allows.
    task automatic noise_beat(input int unsigned n);
        int unsigned cmd_draw;
        int unsigned id_draw;
        cmd_draw = $urandom_range(0, CMD_RESERVED_HI);
        if ($urandom_range(0, 3) == 0)
            id_draw = $urandom_range(0, MAX_WIRE_ID);
        else
            id_draw = $urandom_range(0, n + 1);
        send_beat(cmd_draw[tbs_pkg::CMD_W-1:0], id_draw[tbs_pkg::ID_W-1:0],
                  $urandom_range(0, 1) ? last_epoch : rand64(), rand64());
    endtask

    // Response side: for every beat it draws a stall, then takes the beat. One
    // long hold-off is served when the stimulus asks for it.
    initial
    begin : rsp_sink
        int stall;
        rsp.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (long_hold_request && long_holds == 0)
            begin
                stall = LONG_HOLD_CYCLES;
                long_holds++;
            end
            else
                stall = brisk ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
        end
    end

    initial
    begin : stimulus
        int unsigned              phase;
        int unsigned              n;
        int unsigned              start_items;
        int unsigned              budget;
        logic [tbs_pkg::TS_W-1:0] t0;

        sb                = new();
        brisk             = 1'b0;
        long_hold_request = 1'b0;
        items_sent        = 0;
        settings_used     = 0;
        last_epoch        = '0;

        // Every input of the unit has a known value from time zero.
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= tbs_pkg::REG_THREAD_COUNT;
        pwdata          <= '0;
        req.valid       <= 1'b0;
        req.cmd         <= tbs_pkg::CMD_REGISTER;
        req.member_id   <= '0;
        req.epoch_stamp <= '0;
        req.arg_value   <= '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With no participants, registration hands out nothing and every id
        // is out of range.
        write_thread_count(0);
        send_beat(tbs_pkg::CMD_REGISTER, 0, '0, '0);
        send_beat(tbs_pkg::CMD_SYNC_START, 1, rand64(), rand64());
        settle();

        // Three participants, walked through a full epoch by hand.
        write_thread_count(3);
        t0 = rand64();
        last_epoch = t0;
        // Ids 1 to 3 are handed out, then registration runs dry.
        repeat (4) send_beat(tbs_pkg::CMD_REGISTER, 0, rand64(), rand64());
        // Id zero, one past the count and the top of the field are all rejected.
        send_beat(tbs_pkg::CMD_SYNC_START, 0, t0, rand64());
        send_beat(tbs_pkg::CMD_SYNC_START, 4, t0, rand64());
        send_beat(tbs_pkg::CMD_GET_ARG, MAX_WIRE_ID, t0, rand64());
        send_beat(tbs_pkg::CMD_SYNC_START, 1, t0, '1);
        send_beat(tbs_pkg::CMD_SYNC_START, 2, t0, '0);
        send_beat(tbs_pkg::CMD_SYNC_START, 3, t0, rand64());
        // A matching read returns the argument; a stale stamp returns zero.
        send_beat(tbs_pkg::CMD_GET_ARG, 1, t0, rand64());
        send_beat(tbs_pkg::CMD_GET_ARG, 2, ~t0, rand64());
        // A stale stamp leaves the used flag alone; a matching one sets it.
        send_beat(tbs_pkg::CMD_MARK_USED, 1, ~t0, rand64());
        send_beat(tbs_pkg::CMD_MARK_USED, 1, t0, rand64());
        // All stamps agree but participants two and three have not used their arguments.
        send_beat(tbs_pkg::CMD_SYNC_COMPLETE, 1, t0, rand64());
        // A completion with the wrong stamp sees everyone out of sync.
        send_beat(tbs_pkg::CMD_SYNC_COMPLETE, 2, '1, rand64());
        send_beat(tbs_pkg::CMD_MARK_USED, 2, t0, rand64());
        // The last completion marks itself used and the barrier is clean.
        send_beat(tbs_pkg::CMD_SYNC_COMPLETE, 3, t0, rand64());
        // Reserved command codes are answered with all fields zero.
        send_beat(CMD_RESERVED_LO, 1, t0, rand64());
        send_beat(CMD_RESERVED_LO + 3'd1, 2, t0, rand64());
        send_beat(CMD_RESERVED_HI, MAX_WIRE_ID, '1, '1);
        // Restart with a zero stamp: the others still hold the old epoch.
        send_beat(tbs_pkg::CMD_SYNC_START, 3, '0, '1);
        send_beat(tbs_pkg::CMD_SYNC_COMPLETE, 3, '0, '0);
        settle();

        // Random phases, each under its own participant count. The first few
        // hit the extremes; a count change leaves the table contents in place.
        phase = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            case (phase)
                0:       n = tbs_pkg::DEF_MAX_THREADS;
                1:       n = 1;
                2:       n = 0;
                3:       n = tbs_pkg::DEF_MAX_THREADS;
                default: n = $urandom_range(0, tbs_pkg::DEF_MAX_THREADS);
            endcase
            write_thread_count(n);
            brisk = (phase % 3 == 1);
            if (phase == 3)
                long_hold_request = 1'b1;
            budget      = (n == 0) ? EMPTY_BUDGET : PHASE_BUDGET;
            start_items = items_sent;
            while (items_sent - start_items < budget)
            begin
                if (n != 0 && $urandom_range(0, 3) != 0)
                    barrier_round(n);
                else
                    noise_beat(n);
            end
            settle();
            phase++;
        end

        if (sb.expected_rsps.size() != 0)
            sb.report_mismatch($sformatf("%0d responses never arrived",
                                         sb.expected_rsps.size()));

        $display("Sent %0d commands under %0d participant counts, %0d long response hold-off.",
                 items_sent, settings_used, long_holds);
        $display("Checked %0d responses: %0d ok, %0d out of sync, %0d not all used, %0d bad id.",
                 sb.checked, sb.status_seen[tbs_pkg::STATUS_OK],
                 sb.status_seen[tbs_pkg::STATUS_OUT_OF_SYNC],
                 sb.status_seen[tbs_pkg::STATUS_NOT_USED],
                 sb.status_seen[tbs_pkg::STATUS_BAD_ID]);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
